/* rtl/core/manchester_frame_transmitter_top_assert.svh */
// Assertion macros used by the Manchester frame transmitter top level
`ifndef MANCHESTER_FRAME_TRANSMITTER_TOP_ASSERT_SVH
`define MANCHESTER_FRAME_TRANSMITTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define MFT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define MFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/mft_pkg.sv */
// Types and constants for the Manchester frame transmitter
package mft_pkg;

    localparam int FrameBytes = 11;
    localparam int CountWidth = 8;

    localparam logic [CountWidth-1:0] FrameHalfBits = 8'd176;
    localparam logic [CountWidth-1:0] LastHalfBit   = 8'd175;

    localparam logic [7:0]  PreambleByte = 8'h55;
    localparam logic [7:0]  ProtocolByte = 8'h01;
    localparam logic [15:0] ChecksumSeed = 16'h1235;

    // byte slot that is read live from the address register
    localparam logic [3:0] AddrByteIdx = 4'd2;
    // half-bit phase value that closes a byte
    localparam logic [3:0] ByteLastHalf = 4'hF;

    localparam logic ModeStart = 1'b0;
    localparam logic ModeTick  = 1'b1;

    typedef logic [7:0] frame_byte_t;
    typedef frame_byte_t [FrameBytes-1:0] frame_t;

    typedef struct packed {
        logic load;
        logic shift;
    } chain_ctrl_t;

endpackage

/* rtl/core/mft_cell.sv */
// One byte cell of the frame shift chain
module mft_cell
(
    input  logic                clk,
    input  mft_pkg::chain_ctrl_t ctrl,
    input  mft_pkg::frame_byte_t load_byte,
    input  mft_pkg::frame_byte_t neighbor_byte,
    output mft_pkg::frame_byte_t cell_byte
);

    mft_pkg::frame_byte_t byte_reg;
    mft_pkg::frame_byte_t byte_next;

    always_comb
    begin
        priority if (ctrl.load)
        begin
            byte_next = load_byte;
        end
        else if (ctrl.shift)
        begin
            byte_next = neighbor_byte;
        end
        else
        begin
            byte_next = byte_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign cell_byte = byte_reg;

endmodule

/* rtl/core/mft_chain.sv */
// Row of byte cells; the head cell holds the byte now on the line, but for the address slot
module mft_chain
(
    input  logic                 clk,
    input  mft_pkg::chain_ctrl_t ctrl,
    input  mft_pkg::frame_t      load_frame,
    output mft_pkg::frame_byte_t head_byte
);

    mft_pkg::frame_t cell_bytes;
    mft_pkg::frame_t neighbor_bytes;

    genvar gi;
    generate
        for (gi = 0; gi < mft_pkg::FrameBytes; gi++)
        begin : g_cell
            // each cell takes its right neighbor's byte; the tail takes zero
            if (gi == mft_pkg::FrameBytes - 1)
            begin : g_tail
                assign neighbor_bytes[gi] = '0;
            end
            else
            begin : g_body
                assign neighbor_bytes[gi] = cell_bytes[gi+1];
            end

            mft_cell u_cell
            (
                .clk           (clk),
                .ctrl          (ctrl),
                .load_byte     (load_frame[gi]),
                .neighbor_byte (neighbor_bytes[gi]),
                .cell_byte     (cell_bytes[gi])
            );
        end
    endgenerate

    assign head_byte = cell_bytes[0];

endmodule

/* rtl/core/manchester_frame_transmitter_top.sv */
// Manchester frame transmitter top level: handshake, half-bit counter, byte chain.
// An accepted request's result is registered into the output register in the next cycle.
// Throughput: one request per cycle; the output register stalls input only when full.
// Bytes advance through an 11-cell chain, one shift per 16 half-bits.
// Reset (rst_n low, asynchronous): idle, line low, address zero, output empty.
module manchester_frame_transmitter_top
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [7:0]  error_code,
    input  logic [15:0] cap_voltage_mv,
    input  logic [7:0]  actual_duty,
    input  logic [7:0]  maximum_duty,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        line_level,
    output logic        sending,
    output logic        frame_done
);

`include "manchester_frame_transmitter_top_assert.svh"

    logic [7:0] addr_reg;

    logic [mft_pkg::CountWidth-1:0] cnt_reg;
    logic [mft_pkg::CountWidth-1:0] cnt_next;
    logic busy_reg;
    logic busy_next;
    logic line_reg;
    logic line_next;
    logic done_next;

    logic out_valid_reg;
    logic out_valid_next;
    logic sending_reg;
    logic done_reg;

    logic in_accept;
    logic start;
    logic tick;

    mft_pkg::chain_ctrl_t chain_ctrl;
    mft_pkg::frame_t      load_frame;
    mft_pkg::frame_byte_t head_byte;
    mft_pkg::frame_byte_t cur_byte;
    logic [15:0]          checksum;

    // Hold input while the result register is full and stalled
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;
    assign start     = in_accept & (mode == mft_pkg::ModeStart);
    assign tick      = in_accept & (mode == mft_pkg::ModeTick) & busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            addr_reg <= cfg_write_data;
        end
    end

    always_comb
    begin
        checksum = mft_pkg::ChecksumSeed
                 + {8'h00, addr_reg}
                 + {8'h00, mft_pkg::ProtocolByte}
                 + {8'h00, error_code}
                 + {8'h00, cap_voltage_mv[7:0]}
                 + {8'h00, cap_voltage_mv[15:8]}
                 + {8'h00, actual_duty}
                 + {8'h00, maximum_duty};

        load_frame[0]  = mft_pkg::PreambleByte;
        load_frame[1]  = mft_pkg::PreambleByte;
        load_frame[2]  = '0;
        load_frame[3]  = mft_pkg::ProtocolByte;
        load_frame[4]  = error_code;
        load_frame[5]  = cap_voltage_mv[7:0];
        load_frame[6]  = cap_voltage_mv[15:8];
        load_frame[7]  = actual_duty;
        load_frame[8]  = maximum_duty;
        load_frame[9]  = checksum[7:0];
        load_frame[10] = checksum[15:8];
    end

    // Advance the chain after the last half-bit of each byte
    assign chain_ctrl.load  = start;
    assign chain_ctrl.shift = tick & (cnt_reg[3:0] == mft_pkg::ByteLastHalf);

    mft_chain u_chain
    (
        .clk        (clk),
        .ctrl       (chain_ctrl),
        .load_frame (load_frame),
        .head_byte  (head_byte)
    );

    // The address byte comes from the register at the time it is sent
    assign cur_byte = (cnt_reg[7:4] == mft_pkg::AddrByteIdx) ? addr_reg : head_byte;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        line_next = line_reg;
        done_next = 1'b0;
        if (start)
        begin
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (tick)
        begin
            line_next = cur_byte[cnt_reg[3:1]] ^ cnt_reg[0];
            cnt_next  = cnt_reg + 8'd1;
            if (cnt_reg == mft_pkg::LastHalfBit)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            line_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            line_reg <= line_next;
        end
    end

    always_comb
    begin
        priority if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sending_reg <= busy_next;
            done_reg    <= done_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_level = line_reg;
    assign sending    = sending_reg;
    assign frame_done = done_reg;

    `MFT_ASSERT_NOW(a_cnt_in_frame, busy_reg, cnt_reg < mft_pkg::FrameHalfBits,
        "half-bit count past frame end while busy")
    `MFT_ASSERT_NOW(a_idle_cnt, !busy_reg,
        (cnt_reg == '0) || (cnt_reg == mft_pkg::FrameHalfBits),
        "idle with a partial half-bit count")
    `MFT_ASSERT_NEXT(a_start_loads, start, busy_reg && (cnt_reg == '0),
        "start request did not restart the frame")
    `MFT_ASSERT_NOW(a_done_ends, out_valid_reg && done_reg, !sending_reg,
        "frame done reported while still sending")

endmodule
